### rtl/core/nops_pkg.sv
// Shared widths, constants and types for the next odd prime search unit.
package nops_pkg;

    localparam int WIDTH   = 31;
    localparam int SQ_W    = WIDTH + 1;
    localparam int TDATA_W = ((WIDTH + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(WIDTH);

    localparam logic [WIDTH-1:0] TOP_VALUE = {WIDTH{1'b1}};
    localparam logic [WIDTH-1:0] D_FIRST   = WIDTH'(3);
    localparam logic [SQ_W-1:0]  SQ_FIRST  = SQ_W'(9);

    // Result of one remainder pass.
    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_res;

endpackage

### rtl/core/nops_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module nops_rem
    import nops_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output t_rem_res         o_res
);

    logic             r_busy;
    logic             r_done;
    logic             r_zero;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_dvd;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_div;
    logic [WIDTH:0]   n_trial;
    logic [WIDTH-1:0] n_rem;

    // Bring in the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        n_trial = {r_rem, r_dvd[WIDTH-1]};
        if (n_trial >= {1'b0, r_div}) begin
            n_trial = n_trial - {1'b0, r_div};
        end
        n_rem = n_trial[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_cnt <= CNT_W'(WIDTH - 1);
        end else if (r_busy) begin
            r_dvd <= {r_dvd[WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
            r_cnt <= r_cnt - CNT_W'(1);
            r_zero <= (n_rem == '0);
        end
    end

    assign o_res.done = r_done;
    assign o_res.zero = r_zero;

endmodule

### rtl/core/next_odd_prime_search_unit.sv
// Top level: next odd prime at or above a start value, by trial division.
// Each trial divisor takes one bound check plus a bit-serial remainder.
// A candidate k is tried against odd divisors from three up to sqrt(k).
// One item is searched at a time; a new start value is taken once the search is done,
// even while the previous result still waits on the output register.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
module next_odd_prime_search_unit
    import nops_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [TDATA_W-1:0] i_s_tdata,   // [WIDTH-1:0] start_value, rest zero
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,   // [WIDTH-1:0] prime_value, rest zero
    output logic               o_m_tuser    // [0] overflow
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_DIV   = 5'b00100,
        S_NEXT  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state           r_state;
    logic [WIDTH-1:0] r_k;
    logic [WIDTH-1:0] r_d;
    logic [SQ_W-1:0]  r_sq;
    logic [WIDTH-1:0] r_res_val;
    logic             r_res_ovf;
    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_val;
    logic             r_out_ovf;
    logic             rem_start;
    t_rem_res         rem_res;
    logic             s_acc;
    logic             out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign rem_start  = (r_state == S_CHECK) && (r_k != WIDTH'(1))
                        && ({1'b0, r_k} >= r_sq);

    nops_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_k),
        .i_divisor  (r_d),
        .o_res      (rem_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_k == WIDTH'(1)) begin
                        r_state <= S_NEXT;
                    end else if ({1'b0, r_k} < r_sq) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem_res.done) begin
                        r_state <= rem_res.zero ? S_NEXT : S_CHECK;
                    end
                end
                S_NEXT: begin
                    r_state <= (r_k == TOP_VALUE) ? S_FIN : S_CHECK;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Divisor and divisor square advance together; a new candidate restarts both.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_k  <= i_s_tdata[WIDTH-1:0] | WIDTH'(1);
                r_d  <= D_FIRST;
                r_sq <= SQ_FIRST;
            end
            S_CHECK: begin
                if (r_k != WIDTH'(1) && {1'b0, r_k} < r_sq) begin
                    r_res_val <= r_k;
                    r_res_ovf <= 1'b0;
                end
            end
            S_DIV: begin
                if (rem_res.done && !rem_res.zero) begin
                    r_d  <= r_d + WIDTH'(2);
                    r_sq <= r_sq + ({1'b0, r_d} << 2) + SQ_W'(4);
                end
            end
            S_NEXT: begin
                if (r_k == TOP_VALUE) begin
                    r_res_val <= '0;
                    r_res_ovf <= 1'b1;
                end else begin
                    r_k  <= r_k + WIDTH'(2);
                    r_d  <= D_FIRST;
                    r_sq <= SQ_FIRST;
                end
            end
            S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_out_val <= r_res_val;
            r_out_ovf <= r_res_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_W'(r_out_val);
    assign o_m_tuser  = r_out_ovf;

endmodule

### rtl/core/nops_chk.sv
// Port-level checker for the next odd prime search unit, with its bind.
module nops_chk
    import nops_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_tvalid,
    input logic               o_s_tready,
    input logic               o_m_tvalid,
    input logic               i_m_tready,
    input logic [TDATA_W-1:0] o_m_tdata,
    input logic               o_m_tuser
);

    // A result beat that is stalled keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[WIDTH-1:0] == '0)
        else $error("overflow result with nonzero value");

    // A regular result is odd and at least three.
    a_odd_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[0] && o_m_tdata[WIDTH-1:0] > WIDTH'(1))
        else $error("result is not an odd value above one");

    // Only one start value is searched at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while a search is running");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata >> WIDTH) == '0)
        else $error("padding bits of result are not zero");

endmodule

bind next_odd_prime_search_unit nops_chk u_nops_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

### test/testbench.sv
// Self-checking testbench for the next odd prime search unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nops_pkg::*;

    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int END_HOLD     = 200;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [WIDTH-1:0] prime_value;
        logic             overflow;
    } prime_result_t;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               s_tvalid   = 1'b0;
    logic [TDATA_W-1:0] s_tdata    = '0;
    logic               m_tready   = 1'b0;
    logic               o_s_tready;
    logic               o_m_tvalid;
    logic [TDATA_W-1:0] o_m_tdata;
    logic               o_m_tuser;

    prime_result_t pending_primes[$];
    int            mismatch_count = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;

    next_odd_prime_search_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),      // [WIDTH-1:0] start_value, rest zero
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),    // [WIDTH-1:0] prime_value, rest zero
        .o_m_tuser  (o_m_tuser)     // [0] overflow
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // First odd prime at or above the start value, by plain trial division.
    function automatic void next_odd_prime(input logic [WIDTH-1:0] start,
                                           output logic [WIDTH-1:0] prime,
                                           output logic ovf);
        longint unsigned top;
        longint unsigned cand;
        longint unsigned div;
        bit              found;
        bit              split;
        bit              stop;
        top   = (64'd1 << WIDTH) - 64'd1;
        cand  = 64'(start) | 64'd1;
        found = 1'b0;
        stop  = 1'b0;
        while (!stop) begin
            split = (cand <= 64'd1);
            for (div = 3; !split && div * div <= cand; div += 2)
                split = (cand % div == 0);
            if (!split) begin
                found = 1'b1;
                stop  = 1'b1;
            end else if (cand >= top) begin
                stop = 1'b1;
            end else begin
                cand += 2;
            end
        end
        prime = found ? cand[WIDTH-1:0] : '0;
        ovf   = !found;
    endfunction

    // Random stalls on the result side.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        prime_result_t want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (pending_primes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result beat with nothing expected: prime %0d overflow %0b",
                             o_m_tdata[WIDTH-1:0], o_m_tuser);
            end else begin
                want = pending_primes.pop_front();
                if (o_m_tdata[WIDTH-1:0] !== want.prime_value
                        || o_m_tuser !== want.overflow) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: expected prime %0d overflow %0b, got %0d %0b",
                                 want.prime_value, want.overflow,
                                 o_m_tdata[WIDTH-1:0], o_m_tuser);
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL next_odd_prime_search_unit");
        $finish;
    end

    // Sends one start value; valid stays high into the next beat unless a gap is drawn.
    task automatic send_start(input logic [WIDTH-1:0] value);
        prime_result_t want;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        next_odd_prime(value, want.prime_value, want.overflow);
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(value);
        do @(posedge i_clk); while (!o_s_tready);
        pending_primes.push_back(want);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_primes.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Zero, one and two all land on three; the rest cover primes, odd composites and gaps.
    task automatic test_small_starts();
        logic [WIDTH-1:0] starts[$] = '{0, 1, 2, 3, 4, 5, 8, 9, 15, 24, 89, 90, 114, 1021};
        foreach (starts[i]) send_start(starts[i]);
    endtask

    // The top value is itself prime, so it comes back unchanged without overflow.
    task automatic test_field_extremes();
        send_start(WIDTH'(1_000_000));
        send_start(WIDTH'(1 << 20));
        send_start(TOP_VALUE);
    endtask

    task automatic test_random_starts(input int count);
        int               pick;
        logic [WIDTH-1:0] value;
        repeat (count) begin
            pick = $urandom_range(99);
            // Search time grows with the square root, so large starts stay rare.
            if (pick < 85)
                value = WIDTH'($urandom_range(4095));
            else if (pick < 99)
                value = WIDTH'($urandom_range(1 << 20));
            else
                value = WIDTH'($urandom_range(1 << 24));
            send_start(value);
        end
    endtask

    // The sender holds off until every result is back, then resumes.
    task automatic test_drain_pause();
        test_random_starts(4);
        wait_for_results();
        test_random_starts(4);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0, 0);
        test_small_starts();
        test_field_extremes();
        test_random_starts(25);

        set_idling(53, 0);
        test_random_starts(25);

        set_idling(0, 53);
        test_random_starts(25);
        test_drain_pause();

        set_idling(29, 29);
        test_random_starts(25);

        wait_for_results();
        repeat (END_HOLD) @(posedge i_clk);
        if (mismatch_count == 0 && pending_primes.size() == 0)
            $display("PASS next_odd_prime_search_unit");
        else
            $display("FAIL next_odd_prime_search_unit");
        $finish;
    end

endmodule
